// ===== src/msns_pkg.sv =====
// Shared types and constants for the monophonic sine note synthesizer.
// Holds the controller/datapath command and status structs, mode codes and fixed tables.
// No dependencies.
package msns_pkg;

    localparam int RATE_W = 18;
    localparam int KEY_W  = 8;
    localparam int GAIN_W = 17;
    localparam int MODE_W = 3;
    localparam int FREQ_W = 30;
    localparam int Q30_W  = 31;
    localparam int AMP_W  = 46;
    localparam int PROD_W = 63;

    localparam int unsigned RATE_DEFAULT = 48000;
    localparam int unsigned FREQ_RESET   = 28835840;
    localparam int unsigned GAIN_RESET   = 65536;

    localparam logic signed [KEY_W-1:0] KEY_NONE = -8'sd1;

    localparam logic [7:0]       OCT_RECIP = 8'd171;
    localparam logic [Q30_W-1:0] Q30_ONE   = 31'd1073741824;
    localparam logic [Q30_W-1:0] POLY_SEED = 31'd172272;
    localparam logic [Q30_W-1:0] AMP_Q16   = 31'd19661;
    localparam logic [Q30_W-1:0] POLY_COEF [4] = '{
        31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 3'd0,
        MODE_NOTE_ON  = 3'd1,
        MODE_NOTE_OFF = 3'd2,
        MODE_GAIN     = 3'd3,
        MODE_RESET    = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        OP_IDLE  = 4'd0,
        OP_X2    = 4'd1,
        OP_POLY  = 4'd2,
        OP_SINE  = 4'd3,
        OP_AMP   = 4'd4,
        OP_GAIN  = 4'd5,
        OP_EMIT  = 4'd6,
        OP_DLOAD = 4'd7,
        OP_DSTEP = 4'd8
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] coef_sel;
        logic       take_tick;
        logic       take_on;
        logic       take_off;
        logic       take_gain;
        logic       take_reset;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_sts;

    // Q14.16 note frequencies of the top octave, keys 120 to 131
    function automatic logic [FREQ_W-1:0] top_octave(input logic [3:0] sel);
        logic [FREQ_W-1:0] f;
        unique case (sel)
            4'd0:    f = 30'd548668578;
            4'd1:    f = 30'd581294109;
            4'd2:    f = 30'd615859655;
            4'd3:    f = 30'd652480576;
            4'd4:    f = 30'd691279090;
            4'd5:    f = 30'd732384684;
            4'd6:    f = 30'd775934544;
            4'd7:    f = 30'd822074013;
            4'd8:    f = 30'd870957077;
            4'd9:    f = 30'd922746880;
            4'd10:   f = 30'd977616265;
            4'd11:   f = 30'd1035748353;
            default: f = 30'd548668578;
        endcase
        return f;
    endfunction

endpackage

// ===== src/msns_ctrl.sv =====
// Sequencer for the sine note synthesizer: input/output handshake and one-hot state machine.
// Issues datapath commands per step; depends on msns_pkg.
module msns_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [msns_pkg::MODE_W-1:0]   i_mode,
    input  logic                          i_cfg_we,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output msns_pkg::t_cmd                o_cmd,
    input  msns_pkg::t_sts                i_sts
);
    import msns_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_X2    = 9'b000000010,
        S_POLY  = 9'b000000100,
        S_SINE  = 9'b000001000,
        S_AMP   = 9'b000010000,
        S_GAIN  = 9'b000100000,
        S_EMIT  = 9'b001000000,
        S_DLOAD = 9'b010000000,
        S_DIV   = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_coef, n_coef;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       emit_ok;
    logic       emit;

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign accept      = i_in_valid && o_in_ready;
    assign emit_ok     = !r_out_valid || i_out_ready;
    assign emit        = (r_state == S_EMIT) && emit_ok;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_coef  = r_coef;
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_state = S_DLOAD;
                end else if (accept) begin
                    unique case (t_mode'(i_mode))
                        MODE_TICK:    n_state = S_X2;
                        MODE_NOTE_ON: n_state = S_DLOAD;
                        MODE_RESET:   n_state = S_DLOAD;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_X2: begin
                n_state = S_POLY;
                n_coef  = 2'd0;
            end
            S_POLY: begin
                n_coef = r_coef + 2'd1;
                if (r_coef == 2'd3) begin
                    n_state = S_SINE;
                end
            end
            S_SINE:  n_state = S_AMP;
            S_AMP:   n_state = S_GAIN;
            S_GAIN:  n_state = S_EMIT;
            S_EMIT: begin
                if (emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            S_DLOAD: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = OP_IDLE;
        o_cmd.coef_sel   = r_coef;
        o_cmd.take_tick  = accept && (t_mode'(i_mode) == MODE_TICK);
        o_cmd.take_on    = accept && (t_mode'(i_mode) == MODE_NOTE_ON);
        o_cmd.take_off   = accept && (t_mode'(i_mode) == MODE_NOTE_OFF);
        o_cmd.take_gain  = accept && (t_mode'(i_mode) == MODE_GAIN);
        o_cmd.take_reset = accept && (t_mode'(i_mode) == MODE_RESET);
        unique case (r_state)
            S_X2:    o_cmd.op = OP_X2;
            S_POLY:  o_cmd.op = OP_POLY;
            S_SINE:  o_cmd.op = OP_SINE;
            S_AMP:   o_cmd.op = OP_AMP;
            S_GAIN:  o_cmd.op = OP_GAIN;
            S_EMIT:  o_cmd.op = emit ? OP_EMIT : OP_IDLE;
            S_DLOAD: o_cmd.op = OP_DLOAD;
            S_DIV:   o_cmd.op = OP_DSTEP;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_coef      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_coef      <= n_coef;
            r_out_valid <= n_out_valid;
        end
    end

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_IDLE))
        else $error("divider did not return to idle");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_TICK) |=> (r_state == S_X2))
        else $error("tick item did not start the sine sequence");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_out_ready) |=>
        (r_state == S_EMIT && r_out_valid))
        else $error("result overwrote an untaken output");

    a_cfg_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && r_state == S_IDLE) |=> (r_state == S_DLOAD))
        else $error("rate write did not start a step update");

    a_poly_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SINE) |-> ($past(r_state) == S_POLY && $past(r_coef) == 2'd3))
        else $error("polynomial sequence cut short");

endmodule

// ===== src/msns_dp.sv =====
// Datapath of the sine note synthesizer: note state, phase, bit-serial step divider,
// shared Q30 multiplier for the sine polynomial, gain and output rounding. Uses msns_pkg.
module msns_dp #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  msns_pkg::t_cmd                       i_cmd,
    output msns_pkg::t_sts                       o_sts,
    input  logic                                 i_cfg_we,
    input  logic [msns_pkg::RATE_W-1:0]          i_cfg_wdata,
    input  logic signed [msns_pkg::KEY_W-1:0]    i_note_key,
    input  logic [msns_pkg::GAIN_W-1:0]          i_gain_value,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out
);
    import msns_pkg::*;

    localparam int TBL_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int NUM_W  = PHASE_BITS + FREQ_W - 16;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int OUT_SH = 63 - SAMPLE_BITS;
    localparam logic [63:0] RST_NUM  = 64'(FREQ_RESET) << (PHASE_BITS - 16);
    localparam logic [63:0] RST_STEP = (RST_NUM + 64'(RATE_DEFAULT / 2)) / 64'(RATE_DEFAULT);
    localparam logic [63:0] MAXPOS   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    // architectural state
    logic [RATE_W-1:0]        r_rate;
    logic [PHASE_BITS-1:0]    r_phase;
    logic [PHASE_BITS-1:0]    r_step;
    logic [FREQ_W-1:0]        r_freq;
    logic signed [KEY_W-1:0]  r_key;
    logic                     r_gate;
    logic [GAIN_W-1:0]        r_gain;
    logic [CNT_W-1:0]         r_cnt;

    // working registers
    logic [Q30_W-1:0]         r_x, r_x2, r_t, r_s;
    logic                     r_neg;
    logic [AMP_W-1:0]         r_amp;
    logic [PROD_W-1:0]        r_m;
    logic [NUM_W-1:0]         r_dvd;
    logic [RATE_W-1:0]        r_rem;
    logic [SAMPLE_BITS-1:0]   r_sample;

    // sine position within the quarter wave
    logic [TBL_W-1:0]         idx;
    logic [1:0]               quad;
    logic [TBL_W:0]           qpos, qpos_m;
    logic [Q30_W-1:0]         x_new;

    assign idx    = r_phase[PHASE_BITS-1 -: TBL_W];
    assign quad   = idx[TBL_W-1 -: 2];
    assign qpos   = {1'b0, idx[TBL_W-3:0], 2'b00};
    assign qpos_m = quad[0] ? ((TBL_W+1)'(SINE_TABLE_DEPTH) - qpos) : qpos;
    assign x_new  = Q30_W'(qpos_m) << (30 - TBL_W);

    // key to Q14.16 frequency
    logic [6:0]               k;
    logic [14:0]              oct_p;
    logic [3:0]               oct, rem, sh;
    logic [6:0]               rem_full;
    logic [FREQ_W-1:0]        tf;
    logic [FREQ_W:0]          rsum;
    logic [FREQ_W-1:0]        freq_new;

    assign k        = i_note_key[KEY_W-1] ? 7'd0 : i_note_key[6:0];
    assign oct_p    = {8'd0, k} * {7'd0, OCT_RECIP};
    assign oct      = oct_p[14:11];
    assign rem_full = k - 7'({3'd0, oct} * 7'd12);
    assign rem      = rem_full[3:0];
    assign sh       = 4'd10 - oct;
    assign tf       = top_octave(rem);
    assign rsum     = {1'b0, tf} + ((31'd1 << sh) >> 1);
    assign freq_new = FREQ_W'(rsum >> sh);

    // step divider
    logic [RATE_W-1:0]        dv;
    logic [RATE_W:0]          rem_sh;
    logic                     ge;

    assign dv     = (r_rate == '0) ? RATE_W'(RATE_DEFAULT) : r_rate;
    assign rem_sh = {r_rem, r_dvd[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, dv};
    assign o_sts.div_last = (r_cnt == '0);

    // shared multiplier
    logic [Q30_W-1:0]         mul_a, mul_b;
    logic [2*Q30_W-1:0]       mul_p;
    logic [31:0]              mul_hi;
    logic [Q30_W-1:0]         s_new;

    always_comb begin
        unique case (i_cmd.op)
            OP_X2: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            OP_POLY: begin
                mul_a = r_x2;
                mul_b = r_t;
            end
            OP_SINE: begin
                mul_a = r_x;
                mul_b = r_t;
            end
            OP_AMP: begin
                mul_a = r_s;
                mul_b = AMP_Q16;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = {{Q30_W{1'b0}}, mul_a} * {{Q30_W{1'b0}}, mul_b};
    assign mul_hi = mul_p[61:30];
    assign s_new  = (mul_hi > 32'(Q30_ONE)) ? Q30_ONE : mul_hi[Q30_W-1:0];

    // rounding and saturation of the output sample
    logic [63:0]              rnd, mag;
    logic [SAMPLE_BITS-1:0]   sat, smp;

    assign rnd = 64'(r_m) + (64'd1 << (OUT_SH - 1));
    assign mag = rnd >> OUT_SH;
    assign sat = (mag > MAXPOS) ? MAXPOS[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0];
    assign smp = !r_gate ? '0 : (r_neg ? (SAMPLE_BITS'(0) - sat) : sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= RATE_W'(RATE_DEFAULT);
            r_phase <= '0;
            r_step  <= RST_STEP[PHASE_BITS-1:0];
            r_freq  <= FREQ_W'(FREQ_RESET);
            r_key   <= KEY_NONE;
            r_gate  <= 1'b0;
            r_gain  <= GAIN_W'(GAIN_RESET);
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (i_cmd.take_tick) begin
                r_phase <= r_phase + r_step;
            end
            if (i_cmd.take_on) begin
                r_key  <= i_note_key;
                r_freq <= freq_new;
                r_gate <= 1'b1;
            end
            if (i_cmd.take_off && (i_note_key[KEY_W-1] || i_note_key == r_key)) begin
                r_gate <= 1'b0;
                r_key  <= KEY_NONE;
            end
            if (i_cmd.take_gain) begin
                r_gain <= i_gain_value;
            end
            if (i_cmd.take_reset) begin
                r_phase <= '0;
                r_gate  <= 1'b0;
                r_key   <= KEY_NONE;
            end
            if (i_cmd.op == OP_DLOAD) begin
                r_cnt <= CNT_W'(NUM_W - 1);
            end
            if (i_cmd.op == OP_DSTEP) begin
                r_step <= {r_step[PHASE_BITS-2:0], ge};
                r_cnt  <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_tick) begin
            r_x   <= x_new;
            r_neg <= quad[1];
            r_t   <= POLY_SEED;
        end
        unique case (i_cmd.op)
            OP_X2:    r_x2 <= mul_hi[Q30_W-1:0];
            OP_POLY:  r_t  <= POLY_COEF[i_cmd.coef_sel] - mul_hi[Q30_W-1:0];
            OP_SINE:  r_s  <= s_new;
            OP_AMP:   r_amp <= mul_p[AMP_W-1:0];
            OP_GAIN:  r_m  <= {{GAIN_W{1'b0}}, r_amp} * {{AMP_W{1'b0}}, r_gain};
            OP_EMIT:  r_sample <= smp;
            OP_DLOAD: begin
                r_dvd <= (NUM_W'(r_freq) << (PHASE_BITS - 16)) + NUM_W'(dv >> 1);
                r_rem <= '0;
            end
            OP_DSTEP: begin
                r_dvd <= r_dvd << 1;
                r_rem <= ge ? RATE_W'(rem_sh - {1'b0, dv}) : rem_sh[RATE_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_sample_out = r_sample;

endmodule

// ===== src/mono_sine_note_synth.sv =====
// Top level of the monophonic sine note synthesizer.
// Joins msns_ctrl (sequencer) and msns_dp (datapath); uses msns_pkg.
//
//   port group     dir   handshake              payload
//   item in        in    i_in_valid/o_in_ready  i_mode, i_note_key, i_gain_value
//   sample out     out   o_out_valid/i_out_ready o_sample_out
//   rate register  in    i_cfg_we               i_cfg_wdata
//
// Tick: the result is set by seven passes through the shared multiplier, one gain product
//   and the output register.
// Note-on, reset item and rate write: a step update by the one-bit-per-cycle step divider.
// Note-off and gain items: taken at accept; the sequencer stays idle.
// Reset is synchronous; the step for 440 Hz at 48000 Hz is loaded directly, no sweep.
// A waiting result stalls the next tick at its last step, and all items behind it; until then other items flow.
module mono_sine_note_synth #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [msns_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [msns_pkg::KEY_W-1:0]    i_note_key,
    input  logic [msns_pkg::GAIN_W-1:0]          i_gain_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out,
    input  logic                                 i_cfg_we,
    input  logic [msns_pkg::RATE_W-1:0]          i_cfg_wdata
);
    import msns_pkg::*;

    t_cmd cmd;
    t_sts sts;

    msns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_cfg_we    (i_cfg_we),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    msns_dp #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_note_key   (i_note_key),
        .i_gain_value (i_gain_value),
        .o_sample_out (o_sample_out)
    );

endmodule
